/* hdl/assert_macros.svh */
// Assertion macros shared by the tone sequencer RTL.
// Depends on nothing; defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define PTS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define PTS_NEVER(lbl, clk_s, rstn_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) else $error(msg);
`else
`define PTS_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define PTS_NEVER(lbl, clk_s, rstn_s, expr, msg)
`endif

`endif

/* hdl/pts_pkg.sv */
// Package of the priority tone sequencer: constants, codes and duty helpers.
// Depends on nothing; used by the input channel interface and the top level.
`default_nettype none
package pts_pkg;

    // The step store depth must be a power of two.
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int PADDR_W = 5;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_PLAY   = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_VOLUME = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        VOL_OFF    = 2'd0,
        VOL_LOW    = 2'd1,
        VOL_MEDIUM = 2'd2,
        VOL_LOUD   = 2'd3
    } volume_t;

    typedef enum logic [2:0] {
        REG_ACTIVE_LOW = 3'd0,
        REG_FULL_SCALE = 3'd1,
        REG_LOW_ON     = 3'd2,
        REG_MEDIUM_ON  = 3'd3,
        REG_HIGH_ON    = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_BEGIN  = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_VOLUME = 2'd3
    } action_t;

    typedef struct packed {
        logic        active_low;
        logic [15:0] full_scale;
        logic [15:0] low_on;
        logic [15:0] medium_on;
        logic [15:0] high_on;
    } duty_cfg_t;

    function automatic logic [ADDR_W-1:0] step_addr(logic [7:0] start, logic [8:0] idx);
        logic [31:0] sum;
        sum = 32'(start) + 32'(idx);
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [15:0] duty_for(volume_t vol, duty_cfg_t cfg);
        logic [15:0] on_time;
        case (vol)
            VOL_LOW:    on_time = cfg.low_on;
            VOL_MEDIUM: on_time = cfg.medium_on;
            VOL_LOUD:   on_time = cfg.high_on;
            default:    on_time = 16'd0;
        endcase
        if (!cfg.active_low) begin
            return on_time;
        end
        return (on_time > cfg.full_scale) ? 16'd0 : (cfg.full_scale - on_time);
    endfunction

endpackage
`default_nettype wire

/* hdl/pts_in_if.sv */
// Input channel of the tone sequencer: valid, ready and one request item.
// Depends on pts_pkg for the mode code.
`default_nettype none
interface pts_in_if;
    logic                valid;
    logic                ready;
    pts_pkg::mode_t      mode;
    logic [31:0]         now_ms;
    logic [7:0]          step_address;
    logic [15:0]         step_frequency;
    logic [15:0]         step_duration;
    logic [7:0]          sequence_start;
    logic [8:0]          sequence_length;
    logic [7:0]          sequence_priority;
    logic [1:0]          volume_level;

    modport source (
        output valid, mode, now_ms, step_address, step_frequency, step_duration,
               sequence_start, sequence_length, sequence_priority, volume_level,
        input  ready
    );
    modport sink (
        input  valid, mode, now_ms, step_address, step_frequency, step_duration,
               sequence_start, sequence_length, sequence_priority, volume_level,
        output ready
    );
endinterface
`default_nettype wire

/* hdl/pts_out_if.sv */
// Output channel of the tone sequencer: valid, ready and one result item.
// Depends on nothing.
`default_nettype none
interface pts_out_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] tone_frequency;
    logic [15:0] pwm_duty;
    logic        is_playing;
    logic        play_accepted;

    modport source (
        output valid, tone_on, tone_frequency, pwm_duty, is_playing, play_accepted,
        input  ready
    );
    modport sink (
        input  valid, tone_on, tone_frequency, pwm_duty, is_playing, play_accepted,
        output ready
    );
endinterface
`default_nettype wire

/* hdl/priority_tone_sequencer_unit.sv */
// Priority tone sequencer: step store memory, sequence control and output register.
// Depends on pts_pkg, pts_in_if, pts_out_if and assert_macros.svh.
// Stages: two register stages, the second stage and then the output register; a result
// is registered in each in turn, and it waits in the output register while the output is stalled.
// Throughput: one item per cycle while the output is not stalled; the step store read in the first
// stage and the tone update in the second overlap, with the step deadline forwarded between them.
// Reset: rst_n clears control state and loads the configuration defaults at once; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module priority_tone_sequencer_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pts_in_if.sink                            in_ch,
    pts_out_if.source                         out_ch,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pts_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    // Configuration registers.
    logic        active_low_reg;
    logic [15:0] full_scale_reg;
    logic [15:0] low_on_reg;
    logic [15:0] medium_on_reg;
    logic [15:0] high_on_reg;
    pts_pkg::duty_cfg_t duty_cfg;
    pts_pkg::reg_index_t reg_sel;
    logic        cfg_write;

    // Sequence control state, updated when an item is accepted.
    logic        playing_reg,  playing_next;
    logic [7:0]  priority_reg, priority_next;
    logic [7:0]  start_reg,    start_next;
    logic [8:0]  length_reg,   length_next;
    logic [8:0]  index_reg,    index_next;
    pts_pkg::volume_t volume_reg, volume_next;

    // Second stage, which owns the memory read data.
    logic             s2_valid_reg;
    pts_pkg::action_t s2_act_reg, act_next;
    logic [31:0]      s2_now_reg;
    logic             s2_accepted_reg, accepted_next;
    logic             s2_playing_reg;

    // Tone state, updated by the second stage.
    logic        tone_active_reg, tone_active_next;
    logic [15:0] freq_reg,        freq_next;
    logic [15:0] duty_reg,        duty_next;
    logic [31:0] deadline_reg,    deadline_next;

    // Step store.
    logic [31:0] store_mem [pts_pkg::STORE_DEPTH];
    logic [31:0] q_reg;
    logic [pts_pkg::ADDR_W-1:0] rd_addr;
    logic [pts_pkg::ADDR_W-1:0] wr_addr;
    logic        mem_we;
    logic        mem_re;

    // Output register.
    logic        out_valid_reg;
    logic        out_tone_on_reg;
    logic [15:0] out_freq_reg;
    logic [15:0] out_duty_reg;
    logic        out_playing_reg;
    logic        out_accepted_reg;

    logic        s2_adv;
    logic        s2_fire;
    logic        accept;
    logic [31:0] new_deadline;
    logic [31:0] deadline_fwd;
    logic [31:0] wrap_diff;
    logic        tick_due;
    logic [8:0]  index_inc;
    logic        play_ok;
    logic [15:0] step_freq;
    logic [15:0] duty_new;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_sel   = pts_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign duty_cfg  = '{active_low: active_low_reg, full_scale: full_scale_reg,
                         low_on: low_on_reg, medium_on: medium_on_reg,
                         high_on: high_on_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg <= 1'b1;
            full_scale_reg <= 16'd1023;
            low_on_reg     <= 16'd20;
            medium_on_reg  <= 16'd100;
            high_on_reg    <= 16'd512;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                pts_pkg::REG_ACTIVE_LOW: active_low_reg <= pwdata[0];
                pts_pkg::REG_FULL_SCALE: full_scale_reg <= pwdata[15:0];
                pts_pkg::REG_LOW_ON:     low_on_reg     <= pwdata[15:0];
                pts_pkg::REG_MEDIUM_ON:  medium_on_reg  <= pwdata[15:0];
                pts_pkg::REG_HIGH_ON:    high_on_reg    <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            pts_pkg::REG_ACTIVE_LOW: prdata = {31'd0, active_low_reg};
            pts_pkg::REG_FULL_SCALE: prdata = {16'd0, full_scale_reg};
            pts_pkg::REG_LOW_ON:     prdata = {16'd0, low_on_reg};
            pts_pkg::REG_MEDIUM_ON:  prdata = {16'd0, medium_on_reg};
            pts_pkg::REG_HIGH_ON:    prdata = {16'd0, high_on_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // Handshake.
    assign s2_adv      = !out_valid_reg || out_ch.ready;
    assign s2_fire     = s2_valid_reg && s2_adv;
    assign in_ch.ready = !s2_valid_reg || s2_adv;
    assign accept      = in_ch.valid && in_ch.ready;

    // A step starting in the second stage sets the deadline that a tick in the
    // first stage must see in the same cycle.
    assign new_deadline = s2_now_reg + 32'(q_reg[15:0]);
    assign deadline_fwd = (s2_valid_reg && (s2_act_reg == pts_pkg::ACT_BEGIN))
                          ? new_deadline : deadline_reg;
    assign wrap_diff    = in_ch.now_ms - deadline_fwd;
    assign tick_due     = playing_reg && !wrap_diff[31];
    assign index_inc    = index_reg + 9'd1;
    assign play_ok      = (in_ch.sequence_length != 9'd0)
                          && !(playing_reg && (in_ch.sequence_priority < priority_reg));

    // First stage: control decisions and the store address.
    always_comb
    begin
        playing_next  = playing_reg;
        priority_next = priority_reg;
        start_next    = start_reg;
        length_next   = length_reg;
        index_next    = index_reg;
        volume_next   = volume_reg;
        act_next      = pts_pkg::ACT_NONE;
        accepted_next = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_addr       = pts_pkg::step_addr(start_reg, index_reg);
        wr_addr       = pts_pkg::step_addr(in_ch.step_address, 9'd0);
        unique case (in_ch.mode)
            pts_pkg::MODE_LOAD:
            begin
                mem_we = accept;
            end
            pts_pkg::MODE_PLAY:
            begin
                if (play_ok)
                begin
                    start_next    = in_ch.sequence_start;
                    length_next   = in_ch.sequence_length;
                    priority_next = in_ch.sequence_priority;
                    index_next    = 9'd0;
                    playing_next  = 1'b1;
                    accepted_next = 1'b1;
                    act_next      = pts_pkg::ACT_BEGIN;
                    mem_re        = accept;
                    rd_addr       = pts_pkg::step_addr(in_ch.sequence_start, 9'd0);
                end
            end
            pts_pkg::MODE_TICK:
            begin
                if (tick_due)
                begin
                    index_next = index_inc;
                    if (index_inc >= length_reg)
                    begin
                        playing_next = 1'b0;
                        act_next     = pts_pkg::ACT_STOP;
                    end
                    else
                    begin
                        act_next = pts_pkg::ACT_BEGIN;
                        mem_re   = accept;
                        rd_addr  = pts_pkg::step_addr(start_reg, index_inc);
                    end
                end
            end
            pts_pkg::MODE_VOLUME:
            begin
                volume_next = pts_pkg::volume_t'(in_ch.volume_level);
                act_next    = pts_pkg::ACT_VOLUME;
                mem_re      = accept;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg  <= 1'b0;
            priority_reg <= 8'd0;
            start_reg    <= 8'd0;
            length_reg   <= 9'd0;
            index_reg    <= 9'd0;
            volume_reg   <= pts_pkg::VOL_MEDIUM;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                playing_reg  <= playing_next;
                priority_reg <= priority_next;
                start_reg    <= start_next;
                length_reg   <= length_next;
                index_reg    <= index_next;
                volume_reg   <= volume_next;
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_act_reg      <= act_next;
            s2_now_reg      <= in_ch.now_ms;
            s2_accepted_reg <= accepted_next;
            s2_playing_reg  <= playing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= {in_ch.step_frequency, in_ch.step_duration};
        end
        if (mem_re)
        begin
            q_reg <= store_mem[rd_addr];
        end
    end

    // Second stage: tone update from the step read out of the store, a stop or a volume change.
    assign step_freq = q_reg[31:16];
    assign duty_new  = pts_pkg::duty_for(volume_reg, duty_cfg);

    always_comb
    begin
        tone_active_next = tone_active_reg;
        freq_next        = freq_reg;
        duty_next        = duty_reg;
        deadline_next    = deadline_reg;
        case (s2_act_reg)
            pts_pkg::ACT_BEGIN:
            begin
                deadline_next = new_deadline;
                if ((step_freq == 16'd0) || (volume_reg == pts_pkg::VOL_OFF))
                begin
                    tone_active_next = 1'b0;
                    freq_next        = 16'd0;
                    duty_next        = 16'd0;
                end
                else
                begin
                    tone_active_next = 1'b1;
                    freq_next        = step_freq;
                    duty_next        = duty_new;
                end
            end
            pts_pkg::ACT_STOP:
            begin
                tone_active_next = 1'b0;
                freq_next        = 16'd0;
                duty_next        = 16'd0;
            end
            pts_pkg::ACT_VOLUME:
            begin
                if (s2_playing_reg && (step_freq != 16'd0)
                    && (volume_reg != pts_pkg::VOL_OFF))
                begin
                    if (tone_active_reg)
                    begin
                        duty_next = duty_new;
                    end
                end
                else
                begin
                    tone_active_next = 1'b0;
                    freq_next        = 16'd0;
                    duty_next        = 16'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_active_reg <= 1'b0;
            freq_reg        <= 16'd0;
            duty_reg        <= 16'd0;
            deadline_reg    <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s2_fire)
            begin
                tone_active_reg <= tone_active_next;
                freq_reg        <= freq_next;
                duty_reg        <= duty_next;
                deadline_reg    <= deadline_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_tone_on_reg  <= tone_active_next;
            out_freq_reg     <= freq_next;
            out_duty_reg     <= duty_next;
            out_playing_reg  <= s2_playing_reg;
            out_accepted_reg <= s2_accepted_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.tone_on        = out_tone_on_reg;
    assign out_ch.tone_frequency = out_freq_reg;
    assign out_ch.pwm_duty       = out_duty_reg;
    assign out_ch.is_playing     = out_playing_reg;
    assign out_ch.play_accepted  = out_accepted_reg;

    `PTS_ASSERT(a_accept_fills_stage, clk, rst_n, accept |=> s2_valid_reg, "accepted item lost")
    `PTS_ASSERT(a_silent_is_zero, clk, rst_n, (out_valid_reg && !out_tone_on_reg) |-> ((out_freq_reg == 16'd0) && (out_duty_reg == 16'd0)), "silent result carries tone data")
    `PTS_ASSERT(a_tone_has_freq, clk, rst_n, (out_valid_reg && out_tone_on_reg) |-> (out_freq_reg != 16'd0), "sounding result without frequency")
    `PTS_ASSERT(a_accept_means_playing, clk, rst_n, (out_valid_reg && out_accepted_reg) |-> out_playing_reg, "accepted play not playing")

endmodule
`default_nettype wire
